// ===== hdl/mg2em_pkg.sv =====
package mg2em_pkg;

  // Fixed field widths of the ports
  localparam int PIX_IN_W  = 8;
  localparam int PIX_OUT_W = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Frame height limits and counter width
  localparam int HEIGHT_MAX = 1024;
  localparam int HT_W       = 11;
  localparam int ROW_W      = 10;
  localparam int DIM_MIN    = 2;
  localparam int DIM_RESET  = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Control that travels with a completed window
  typedef struct packed {
    logic valid;
    logic last;
  } win_ctrl_t;

endpackage

// ===== hdl/mg2em_window.sv =====
module mg2em_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mg2em_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mg2em_pkg::CFG_W-1:0]       cfg_data,
  input  logic [mg2em_pkg::PIX_IN_W-1:0]    pixel_value,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              adv,
  output logic [PIXEL_BITS-1:0]             p1,
  output logic [PIXEL_BITS-1:0]             p2,
  output logic [PIXEL_BITS-1:0]             p3,
  output logic [PIXEL_BITS-1:0]             p4,
  output mg2em_pkg::win_ctrl_t              ctrl
);

  localparam int CW      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RESET_W = (MAX_WIDTH < mg2em_pkg::DIM_RESET) ? MAX_WIDTH
                                                              : mg2em_pkg::DIM_RESET;

  logic [WW-1:0]                    image_width;
  logic [mg2em_pkg::HT_W-1:0]       image_height;
  logic [CW-1:0]                    column_count;
  logic [mg2em_pkg::ROW_W-1:0]      row_count;
  logic [PIXEL_BITS-1:0]            left_pixel;
  logic [PIXEL_BITS-1:0]            upper_left_pixel;
  logic [PIXEL_BITS-1:0]            upper_rd;
  logic [PIXEL_BITS-1:0]            row_store [MAX_WIDTH];

  logic [PIXEL_BITS-1:0]            pix;
  logic [WW-1:0]                    col_inc;
  logic [mg2em_pkg::HT_W-1:0]       row_inc;
  logic                             col_wrap;
  logic                             row_wrap;
  logic [CW-1:0]                    column_count_next;
  logic [mg2em_pkg::ROW_W-1:0]      row_count_next;
  logic                             accept;
  logic                             produce;
  logic [WW-1:0]                    width_sat;
  logic [mg2em_pkg::HT_W-1:0]       height_sat;

  assign pix      = PIXEL_BITS'(pixel_value);
  assign in_ready = !ctrl.valid || adv;
  assign accept   = in_valid && in_ready;
  assign produce  = (row_count != '0) && (column_count != '0);

  assign col_inc  = WW'(column_count) + WW'(1);
  assign row_inc  = mg2em_pkg::HT_W'(row_count) + mg2em_pkg::HT_W'(1);
  assign col_wrap = col_inc >= image_width;
  assign row_wrap = row_inc >= image_height;

  assign column_count_next = col_wrap ? '0 : CW'(col_inc);
  always_comb begin
    if (!col_wrap) begin
      row_count_next = row_count;
    end else if (row_wrap) begin
      row_count_next = '0;
    end else begin
      row_count_next = mg2em_pkg::ROW_W'(row_inc);
    end
  end

  always_comb begin
    if (cfg_data < mg2em_pkg::CFG_W'(mg2em_pkg::DIM_MIN)) begin
      width_sat = WW'(mg2em_pkg::DIM_MIN);
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      width_sat = WW'(MAX_WIDTH);
    end else begin
      width_sat = WW'(cfg_data);
    end
    if (cfg_data < mg2em_pkg::CFG_W'(mg2em_pkg::DIM_MIN)) begin
      height_sat = mg2em_pkg::HT_W'(mg2em_pkg::DIM_MIN);
    end else if (32'(cfg_data) > mg2em_pkg::HEIGHT_MAX) begin
      height_sat = mg2em_pkg::HT_W'(mg2em_pkg::HEIGHT_MAX);
    end else begin
      height_sat = cfg_data;
    end
  end

  // Counters and frame size; any register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WW'(RESET_W);
      image_height <= mg2em_pkg::HT_W'(mg2em_pkg::DIM_RESET);
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mg2em_pkg::REG_IMAGE_WIDTH: begin
          image_width  <= width_sat;
          column_count <= '0;
          row_count    <= '0;
        end
        mg2em_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= height_sat;
          column_count <= '0;
          row_count    <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line store: write this column, prefetch the next column's upper pixel.
  // Addresses never collide since a row is at least two pixels wide.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[column_count] <= pix;
      upper_rd                <= row_store[column_count_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (accept) begin
      left_pixel       <= pix;
      upper_left_pixel <= upper_rd;
    end
  end

  // Window register feeding the gradient stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (accept) begin
      ctrl.valid <= produce;
      ctrl.last  <= col_wrap && row_wrap;
    end else if (adv) begin
      ctrl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= upper_left_pixel;
      p2 <= upper_rd;
      p3 <= left_pixel;
      p4 <= pix;
    end
  end

endmodule

// ===== hdl/mg2em_grad.sv =====
module mg2em_grad #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [PIXEL_BITS-1:0]            p1,
  input  logic [PIXEL_BITS-1:0]            p2,
  input  logic [PIXEL_BITS-1:0]            p3,
  input  logic [PIXEL_BITS-1:0]            p4,
  input  mg2em_pkg::win_ctrl_t             ctrl,
  output logic                             adv,
  output logic [mg2em_pkg::PIX_OUT_W-1:0]  edge_strength,
  output logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_ready
);

  localparam int PW = PIXEL_BITS;

  logic [PW:0]   h_pos, h_neg, h_mag;
  logic [PW:0]   v_pos, v_neg, v_mag;
  logic [PW-1:0] gh, gv, gp, gn;
  logic [PW-1:0] m_hv, m_pn, g;

  assign adv = !out_valid || out_ready;

  always_comb begin
    // horizontal: (p1 + p3) - (p2 + p4); vertical: (p1 + p2) - (p3 + p4)
    h_pos = {1'b0, p1} + {1'b0, p3};
    h_neg = {1'b0, p2} + {1'b0, p4};
    v_pos = {1'b0, p1} + {1'b0, p2};
    v_neg = {1'b0, p3} + {1'b0, p4};
    h_mag = (h_pos > h_neg) ? h_pos - h_neg : h_neg - h_pos;
    v_mag = (v_pos > v_neg) ? v_pos - v_neg : v_neg - v_pos;
    gh    = h_mag[PW:1];
    gv    = v_mag[PW:1];
    gp    = (p1 > p4) ? p1 - p4 : p4 - p1;
    gn    = (p2 > p3) ? p2 - p3 : p3 - p2;
    m_hv  = (gh > gv) ? gh : gv;
    m_pn  = (gp > gn) ? gp : gn;
    g     = (m_hv > m_pn) ? m_hv : m_pn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctrl.valid) begin
      edge_strength <= mg2em_pkg::PIX_OUT_W'(g);
      frame_end     <= ctrl.last;
    end
  end

endmodule

// ===== hdl/max_gradient_2x2_edge_map_core.sv =====
// Channel  Handshake               Payload
// -------  ----------------------  --------------------------------------
// pixel    in_valid / in_ready     pixel_value[7:0]
// edge     out_valid / out_ready   edge_strength[7:0], frame_end
// config   cfg_we (no wait)        cfg_index[0], cfg_data[10:0]
//
// One pixel per cycle sustained while results are taken; a bottom-right
// pixel's result passes window register, then gradient/result register.
// The line store is read one column ahead, so each pixel uses one write and
// one prefetch read of the store in its accept cycle.
// Reset clears counters and pipeline valids; the line store is not cleared
// and no pass over it is needed, so pixels are taken right after reset.
// A stalled result holds both stages. Pixels that complete no window keep
// entering while the result register waits; the input stalls once a pixel
// that completes a window sits in the window register.
module max_gradient_2x2_edge_map_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mg2em_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mg2em_pkg::CFG_W-1:0]      cfg_data,
  input  logic [mg2em_pkg::PIX_IN_W-1:0]   pixel_value,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic [mg2em_pkg::PIX_OUT_W-1:0]  edge_strength,
  output logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_ready
);

  logic [PIXEL_BITS-1:0] p1, p2, p3, p4;
  mg2em_pkg::win_ctrl_t  ctrl;
  logic                  adv;

  mg2em_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adv         (adv),
    .p1          (p1),
    .p2          (p2),
    .p3          (p3),
    .p4          (p4),
    .ctrl        (ctrl)
  );

  mg2em_grad #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_grad (
    .clk           (clk),
    .rst           (rst),
    .p1            (p1),
    .p2            (p2),
    .p3            (p3),
    .p4            (p4),
    .ctrl          (ctrl),
    .adv           (adv),
    .edge_strength (edge_strength),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule

// ===== hdl/mg2em_checker.sv =====
module mg2em_checker (
  input logic                             clk,
  input logic                             rst,
  input logic [mg2em_pkg::PIX_IN_W-1:0]   pixel_value,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [mg2em_pkg::PIX_OUT_W-1:0]  edge_strength,
  input logic                             frame_end,
  input logic                             out_valid,
  input logic                             out_ready
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_strength) && $stable(frame_end))
    else $error("stalled result changed");

  // A waiting pixel transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(pixel_value))
    else $error("waiting pixel changed");

  // An empty result register never blocks the pixel side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pixel side blocked with empty output");

  // A fresh result comes from a pixel transaction via the window register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching pixel transaction");

endmodule

bind max_gradient_2x2_edge_map_core mg2em_checker u_checker (.*);
